// ----- design/piah_pkg.sv -----
// Shared types and codes for the idle page age histogram.
`timescale 1ns / 1ps

package piah_pkg;

  localparam logic [1:0] ACT_PAGE  = 2'd0;
  localparam logic [1:0] ACT_READ  = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam int FLAG_LRU_BIT     = 5;
  localparam int FLAG_ANON_BIT    = 12;
  localparam int FLAG_TAIL_BIT    = 16;
  localparam int FLAG_UNEVICT_BIT = 18;

  localparam int AGE_W = 8;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] page_index;
    logic [63:0] page_flags;
    logic        idle_bit;
    logic [3:0]  group_slot;
    logic        mem_kind;
    logic [7:0]  age_bin;
    logic        want_total;
  } page_in_t;

  typedef struct packed {
    logic [7:0]  new_age;
    logic        counted;
    logic        was_idle;
    logic [31:0] count_value;
  } page_out_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_RUN,
    ST_DRAIN,
    ST_CLEAR
  } sweep_state_t;

endpackage

// ----- design/page_idle_age_histogram.sv -----
// Idle page age histogram: age store, per-group idle bins and totals.
`timescale 1ns / 1ps

// Takes one request per cycle while in_ready is high and returns one result per request,
// through an eight-entry result queue. The rate is set by the age memory,
// read in the index stage and rewritten one stage later, and by the counter memories,
// read and rewritten one stage after that; each read-modify-write forwards the value
// written in the previous cycle. After reset the block sweeps its memories to zero
// with in_ready low. A clear request drains the pipeline and then sweeps the counter
// memories; in_ready stays low from the clear until that sweep ends.
module page_idle_age_histogram import piah_pkg::*; #(
  parameter int PAGES       = 65536,
  parameter int GROUP_SLOTS = 16,
  parameter int AGE_LEVELS  = 256,
  parameter int COUNT_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  page_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output page_out_t out_data
);

  localparam int PAW       = $clog2(PAGES);
  localparam int SW        = (GROUP_SLOTS > 1) ? $clog2(GROUP_SLOTS) : 1;
  localparam int GTW       = SW + 1;
  localparam int TOT_DEPTH = GROUP_SLOTS * 2;
  localparam int BW        = $clog2(AGE_LEVELS);
  localparam int BIN_DEPTH = TOT_DEPTH * AGE_LEVELS;
  localparam int BNW       = $clog2(BIN_DEPTH);
  localparam int SWEEP_N   = (PAGES > BIN_DEPTH) ? PAGES : BIN_DEPTH;
  localparam int SCW       = $clog2(SWEEP_N);
  localparam int SH        = 16 + PAW;
  localparam longint unsigned RECIP =
    ((64'd1 << SH) + 64'(PAGES) - 64'd1) / 64'(PAGES);
  localparam logic [15:0] P_LO = 16'(PAGES % 65536);
  localparam int FIFO_DEPTH = 8;
  localparam int FPW        = 3;

  sweep_state_t state_r, state_nxt;
  logic [SCW-1:0] swp_cnt_r, swp_cnt_nxt;
  logic sweep_run, sweep_ages, accepting;

  logic [SW-1:0] hd_group_r;
  logic hd_lru_r, hd_anon_r, hd_unev_r, hd_idle_r;

  logic [SW-1:0] slot_tbl [16];
  logic [SW-1:0] in_slot;
  logic in_fire, in_rec, in_head;
  logic [SW-1:0] eff_group;
  logic eff_lru, eff_anon, eff_unev, eff_idle;
  logic [33:0] page_prod;
  logic [BW-1:0] in_bin;

  logic a_v_r, b_v_r, c_v_r;
  logic [1:0] a_act_r, b_act_r, c_act_r;
  logic [15:0] a_page_r, a_q_r;
  logic a_cnt_r, b_cnt_r, c_cnt_r;
  logic a_idle_r, b_idle_r, c_idle_r;
  logic [GTW-1:0] a_gt_r, b_gt_r, c_gt_r;
  logic [BW-1:0] a_bin_r, b_bin_r;
  logic a_tot_r, b_tot_r, c_tot_r;
  logic [PAW-1:0] b_page_r;
  logic [BNW-1:0] c_baddr_r;
  logic [AGE_W-1:0] c_age_r;

  logic [15:0] a_rem;
  logic [PAW-1:0] a_idx;

  logic [AGE_W-1:0] age_mem [PAGES];
  logic [AGE_W-1:0] age_rd_r;
  logic age_we;
  logic [PAW-1:0] age_waddr;
  logic [AGE_W-1:0] age_wdata;
  logic aw_v_r;
  logic [PAW-1:0] aw_addr_r;
  logic [AGE_W-1:0] aw_data_r;

  logic [AGE_W-1:0] age_cur, age_new;
  logic b_age_we;
  logic [BW-1:0] bin_sel;
  logic [BNW-1:0] b_baddr;

  logic [COUNT_WIDTH-1:0] bin_mem [BIN_DEPTH];
  logic [COUNT_WIDTH-1:0] tot_mem [TOT_DEPTH];
  logic [COUNT_WIDTH-1:0] bin_rd_r, tot_rd_r;
  logic bin_we, tot_we;
  logic [BNW-1:0] bin_waddr;
  logic [GTW-1:0] tot_waddr;
  logic [COUNT_WIDTH-1:0] bin_wdata, tot_wdata;
  logic bw_v_r, tw_v_r;
  logic [BNW-1:0] bw_addr_r;
  logic [GTW-1:0] tw_addr_r;
  logic [COUNT_WIDTH-1:0] bw_data_r, tw_data_r;

  logic [COUNT_WIDTH-1:0] bin_cur, tot_cur, bin_inc, tot_inc, sel_cnt;
  logic c_bin_we, c_tot_we;
  logic swp_age, swp_bin, swp_tot;
  page_out_t c_res;

  page_out_t fifo_r [FIFO_DEPTH];
  logic [FPW-1:0] wr_ptr_r, rd_ptr_r;
  logic [FPW:0] fcnt_r, inflight;
  logic push, pop;

  for (genvar i = 0; i < 16; i++) begin : g_slot
    localparam int M = i % GROUP_SLOTS;
    assign slot_tbl[i] = SW'(M);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:  if (swp_cnt_r == SCW'(SWEEP_N - 1)) state_nxt = ST_RUN;
      ST_RUN:   if (in_fire && in_data.action == ACT_CLEAR) state_nxt = ST_DRAIN;
      ST_DRAIN: if (c_v_r && c_act_r == ACT_CLEAR) state_nxt = ST_CLEAR;
      ST_CLEAR: if (swp_cnt_r == SCW'(BIN_DEPTH - 1)) state_nxt = ST_RUN;
      default:  state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    sweep_run  = 1'b0;
    sweep_ages = 1'b0;
    accepting  = 1'b0;
    case (state_r)
      ST_INIT: begin
        sweep_run  = 1'b1;
        sweep_ages = 1'b1;
      end
      ST_RUN:   accepting = 1'b1;
      ST_CLEAR: sweep_run = 1'b1;
      default: begin
        sweep_run  = 1'b0;
      end
    endcase
  end

  assign swp_cnt_nxt = sweep_run ? swp_cnt_r + SCW'(1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_INIT;
      swp_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      swp_cnt_r <= swp_cnt_nxt;
    end
  end

  assign swp_age = sweep_ages && ({1'b0, swp_cnt_r} < (SCW + 1)'(PAGES));
  assign swp_bin = sweep_run && ({1'b0, swp_cnt_r} < (SCW + 1)'(BIN_DEPTH));
  assign swp_tot = sweep_run && ({1'b0, swp_cnt_r} < (SCW + 1)'(TOT_DEPTH));

  assign inflight = (FPW + 1)'(a_v_r) + (FPW + 1)'(b_v_r) + (FPW + 1)'(c_v_r);
  assign in_ready = accepting && (fcnt_r + inflight < (FPW + 1)'(FIFO_DEPTH));
  assign in_fire  = in_valid && in_ready;

  assign in_slot = slot_tbl[in_data.group_slot];
  assign in_rec  = in_data.action == ACT_PAGE;
  assign in_head = in_rec && !in_data.page_flags[FLAG_TAIL_BIT];

  assign eff_group = in_head ? in_slot : hd_group_r;
  assign eff_lru   = in_head ? in_data.page_flags[FLAG_LRU_BIT] : hd_lru_r;
  assign eff_anon  = in_head ? in_data.page_flags[FLAG_ANON_BIT] : hd_anon_r;
  assign eff_unev  = in_head ? in_data.page_flags[FLAG_UNEVICT_BIT] : hd_unev_r;
  assign eff_idle  = in_head ? in_data.idle_bit : hd_idle_r;

  assign page_prod = 34'(in_data.page_index) * 34'(RECIP);
  assign in_bin = ({1'b0, in_data.age_bin} >= 9'(AGE_LEVELS)) ? BW'(AGE_LEVELS - 1)
                                                               : BW'(in_data.age_bin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hd_group_r <= '0;
      hd_lru_r   <= 1'b0;
      hd_anon_r  <= 1'b0;
      hd_unev_r  <= 1'b0;
      hd_idle_r  <= 1'b0;
    end else if (in_fire && in_head) begin
      hd_group_r <= eff_group;
      hd_lru_r   <= eff_lru;
      hd_anon_r  <= eff_anon;
      hd_unev_r  <= eff_unev;
      hd_idle_r  <= eff_idle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= in_fire;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    a_act_r  <= in_data.action;
    a_page_r <= in_data.page_index;
    a_q_r    <= 16'(page_prod >> SH);
    a_cnt_r  <= in_rec && eff_lru && !eff_unev;
    a_idle_r <= eff_idle;
    a_gt_r   <= (in_data.action == ACT_READ) ? {in_slot, in_data.mem_kind}
                                             : {eff_group, !eff_anon};
    a_bin_r  <= in_bin;
    a_tot_r  <= in_data.want_total;
  end

  assign a_rem = a_page_r - 16'(a_q_r * P_LO);
  assign a_idx = PAW'(a_rem);

  always_ff @(posedge clk) begin
    b_act_r  <= a_act_r;
    b_page_r <= a_idx;
    b_cnt_r  <= a_cnt_r;
    b_idle_r <= a_idle_r;
    b_gt_r   <= a_gt_r;
    b_bin_r  <= a_bin_r;
    b_tot_r  <= a_tot_r;
  end

  assign age_cur = (aw_v_r && aw_addr_r == b_page_r) ? aw_data_r : age_rd_r;

  always_comb begin
    if (!b_cnt_r) begin
      age_new = age_cur;
    end else if (!b_idle_r) begin
      age_new = '0;
    end else if ({1'b0, age_cur} + 9'd1 < 9'(AGE_LEVELS)) begin
      age_new = age_cur + AGE_W'(1);
    end else begin
      age_new = age_cur;
    end
  end

  assign b_age_we = b_v_r && b_act_r == ACT_PAGE && b_cnt_r;
  assign bin_sel  = (b_act_r == ACT_READ) ? b_bin_r : BW'(age_cur);
  assign b_baddr  = BNW'(b_gt_r) * BNW'(AGE_LEVELS) + BNW'(bin_sel);

  assign age_we    = b_age_we || swp_age;
  assign age_waddr = swp_age ? swp_cnt_r[PAW-1:0] : b_page_r;
  assign age_wdata = swp_age ? '0 : age_new;

  always_ff @(posedge clk) begin
    if (age_we) begin
      age_mem[age_waddr] <= age_wdata;
    end
    age_rd_r <= age_mem[a_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aw_v_r <= 1'b0;
    end else begin
      aw_v_r <= b_age_we;
    end
    aw_addr_r <= b_page_r;
    aw_data_r <= age_new;
  end

  always_ff @(posedge clk) begin
    c_act_r   <= b_act_r;
    c_cnt_r   <= b_cnt_r;
    c_idle_r  <= b_idle_r;
    c_gt_r    <= b_gt_r;
    c_baddr_r <= b_baddr;
    c_tot_r   <= b_tot_r;
    c_age_r   <= age_new;
  end

  assign bin_cur = (bw_v_r && bw_addr_r == c_baddr_r) ? bw_data_r : bin_rd_r;
  assign tot_cur = (tw_v_r && tw_addr_r == c_gt_r) ? tw_data_r : tot_rd_r;
  assign bin_inc = (bin_cur == '1) ? bin_cur : bin_cur + COUNT_WIDTH'(1);
  assign tot_inc = (tot_cur == '1) ? tot_cur : tot_cur + COUNT_WIDTH'(1);

  assign c_tot_we = c_v_r && c_act_r == ACT_PAGE && c_cnt_r;
  assign c_bin_we = c_tot_we && c_idle_r;

  assign bin_we    = c_bin_we || swp_bin;
  assign bin_waddr = swp_bin ? swp_cnt_r[BNW-1:0] : c_baddr_r;
  assign bin_wdata = swp_bin ? '0 : bin_inc;
  assign tot_we    = c_tot_we || swp_tot;
  assign tot_waddr = swp_tot ? swp_cnt_r[GTW-1:0] : c_gt_r;
  assign tot_wdata = swp_tot ? '0 : tot_inc;

  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_waddr] <= bin_wdata;
    end
    bin_rd_r <= bin_mem[b_baddr];
  end

  always_ff @(posedge clk) begin
    if (tot_we) begin
      tot_mem[tot_waddr] <= tot_wdata;
    end
    tot_rd_r <= tot_mem[b_gt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bw_v_r <= 1'b0;
      tw_v_r <= 1'b0;
    end else begin
      bw_v_r <= c_bin_we;
      tw_v_r <= c_tot_we;
    end
    bw_addr_r <= c_baddr_r;
    bw_data_r <= bin_inc;
    tw_addr_r <= c_gt_r;
    tw_data_r <= tot_inc;
  end

  assign sel_cnt = c_tot_r ? tot_cur : bin_cur;

  always_comb begin
    c_res = '0;
    case (c_act_r)
      ACT_PAGE: begin
        c_res.new_age  = c_age_r;
        c_res.counted  = c_cnt_r;
        c_res.was_idle = c_cnt_r && c_idle_r;
      end
      ACT_READ: begin
        c_res.count_value = (COUNT_WIDTH > 32 && (sel_cnt >> 32) != '0) ? 32'hFFFF_FFFF
                                                                       : 32'(sel_cnt);
      end
      default: c_res = '0;
    endcase
  end

  assign push      = c_v_r;
  assign out_valid = fcnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign out_data  = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= c_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + FPW'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + FPW'(1);
      fcnt_r <= fcnt_r + (FPW + 1)'(push) - (FPW + 1)'(pop);
    end
  end

endmodule

// ----- design/piah_checker.sv -----
// Port-level checks for the idle page age histogram and their binding.
`timescale 1ns / 1ps

module piah_checker import piah_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input page_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input page_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_idle_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.was_idle |-> out_data.counted && out_data.new_age != '0)
    else $error("idle result without count or with zero age");

  a_record_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.counted |-> out_data.count_value == '0)
    else $error("counted record carries a counter value");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action == ACT_CLEAR |=> !in_ready)
    else $error("request taken right after a clear");

endmodule

bind page_idle_age_histogram piah_checker u_piah_checker (.*);
